FILE: hw/rtl/rbf_pkg.sv
// Package for the ring buffer FIFO: field widths, request codes, FSM encoding
// and parameter defaults. Depends on nothing.
package rbf_pkg;

    localparam int DEPTH_DEF      = 1024;
    localparam int ELEM_WIDTH_DEF = 32;
    localparam int MAX_BURST_DEF  = 64;

    localparam int REQ_W  = 3;
    localparam int DATA_W = 32;
    localparam int CNT_W  = 10;
    localparam int LVL_W  = 10;

    typedef enum logic [REQ_W-1:0] {
        REQ_WRITE     = 3'd0,
        REQ_READ      = 3'd1,
        REQ_PEEK      = 3'd2,
        REQ_ADV_READ  = 3'd3,
        REQ_ADV_WRITE = 3'd4,
        REQ_CLEAR     = 3'd5,
        REQ_QUERY     = 3'd6
    } req_t;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_BURST = 3'b100
    } state_t;

endpackage

FILE: hw/rtl/rbf_mem.sv
// Element store of the ring buffer FIFO: one write port, one read port with
// an enabled read data register. No package dependency.
module rbf_mem #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_array[waddr] <= wdata;
        end
    end

    // Hold the read data until the next read is issued.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/ring_buffer_fifo.sv
// Top level of the ring buffer FIFO: request decode, index registers, burst
// sequencer and result register. Uses rbf_pkg and rbf_mem.
//
//   channel   ports                                   direction
//   request   s_valid s_ready s_req_type s_data_in    in
//             s_count
//   result    m_valid m_ready m_data_out              out
//             m_element_valid m_last m_accepted
//             m_fill_level m_free_level
//
// Write, advance, query and unused codes each give one result; clear gives
// its result and then runs the clearing pass below.
// Read and peek of n = min(count, fill, MAX_BURST) elements are accepted,
// the first element is fetched, then one element per cycle comes out of the
// store's read port while the result side does not stall; its read register holds on stall.
// After reset and after a clear, a clearing pass writes zero to all DEPTH
// entries, one per cycle, with s_ready low.
// The result register lets a request be accepted while the previous result
// waits, as long as that result is taken in the same cycle.
module ring_buffer_fifo #(
    parameter int DEPTH      = rbf_pkg::DEPTH_DEF,
    parameter int ELEM_WIDTH = rbf_pkg::ELEM_WIDTH_DEF,
    parameter int MAX_BURST  = rbf_pkg::MAX_BURST_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [rbf_pkg::REQ_W-1:0]  s_req_type,
    input  logic [rbf_pkg::DATA_W-1:0] s_data_in,
    input  logic [rbf_pkg::CNT_W-1:0]  s_count,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [rbf_pkg::DATA_W-1:0] m_data_out,
    output logic                       m_element_valid,
    output logic                       m_last,
    output logic                       m_accepted,
    output logic [rbf_pkg::LVL_W-1:0]  m_fill_level,
    output logic [rbf_pkg::LVL_W-1:0]  m_free_level
);

    import rbf_pkg::*;

    localparam int IDX_W   = $clog2(DEPTH);
    localparam int BURST_W = $clog2(MAX_BURST + 1);
    localparam int CMP_W   = (IDX_W > CNT_W) ? IDX_W : CNT_W;
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(DEPTH - 1);
    localparam logic [CMP_W-1:0] BURST_LIM  = CMP_W'(MAX_BURST);

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0]     wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0]     clr_addr_reg, clr_addr_next;
    logic [IDX_W-1:0]     rd_addr_reg, rd_addr_next;
    logic [BURST_W-1:0]   issue_left_reg, issue_left_next;
    logic [BURST_W-1:0]   deliver_left_reg, deliver_left_next;
    logic                 rd_pend_reg, rd_pend_next;

    logic                 m_valid_reg;
    logic [DATA_W-1:0]    data_out_reg;
    logic                 elem_valid_reg;
    logic                 last_reg;
    logic                 accepted_reg;
    logic [LVL_W-1:0]     fill_reg;
    logic [LVL_W-1:0]     free_reg;

    logic                 out_free;
    logic                 accept;
    logic                 load_single;
    logic                 single_acc;
    logic                 deliver;
    logic                 issue;

    logic [IDX_W-1:0]     fill_cur, free_cur;
    logic [IDX_W-1:0]     fill_nx, free_nx;
    logic [CMP_W-1:0]     n_cmp;
    logic [BURST_W-1:0]   n_burst;

    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [ELEM_WIDTH-1:0] mem_wdata;
    logic [ELEM_WIDTH-1:0] mem_rdata;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;

    assign fill_cur = wr_idx_reg - rd_idx_reg;
    assign free_cur = rd_idx_reg - wr_idx_reg - IDX_W'(1);
    assign fill_nx  = wr_idx_next - rd_idx_next;
    assign free_nx  = rd_idx_next - wr_idx_next - IDX_W'(1);

    // Burst length: min(count, fill, MAX_BURST).
    always_comb begin
        n_cmp = CMP_W'(s_count);
        if (CMP_W'(fill_cur) < n_cmp) begin
            n_cmp = CMP_W'(fill_cur);
        end
        if (BURST_LIM < n_cmp) begin
            n_cmp = BURST_LIM;
        end
        n_burst = BURST_W'(n_cmp);
    end

    // Burst read pipe: issue while the read register will be free next cycle.
    assign issue   = (state_reg == ST_BURST) && (issue_left_reg != '0)
                     && (!rd_pend_reg || out_free);
    assign deliver = (state_reg == ST_BURST) && rd_pend_reg && out_free;

    always_comb begin
        state_next        = state_reg;
        rd_idx_next       = rd_idx_reg;
        wr_idx_next       = wr_idx_reg;
        clr_addr_next     = clr_addr_reg;
        rd_addr_next      = rd_addr_reg;
        issue_left_next   = issue_left_reg;
        deliver_left_next = deliver_left_reg;
        rd_pend_next      = issue || (rd_pend_reg && !out_free);
        load_single       = 1'b0;
        single_acc        = 1'b0;
        mem_we            = 1'b0;
        mem_waddr         = wr_idx_reg;
        mem_wdata         = ELEM_WIDTH'(s_data_in);

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + IDX_W'(1);
                if (clr_addr_reg == LAST_IDX) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_req_type) inside
                        REQ_WRITE: begin
                            load_single = 1'b1;
                            if (free_cur != '0) begin
                                mem_we      = 1'b1;
                                wr_idx_next = wr_idx_reg + IDX_W'(1);
                                single_acc  = 1'b1;
                            end
                        end
                        REQ_READ, REQ_PEEK: begin
                            if (n_burst == '0) begin
                                load_single = 1'b1;
                            end else begin
                                state_next        = ST_BURST;
                                rd_addr_next      = rd_idx_reg;
                                issue_left_next   = n_burst;
                                deliver_left_next = n_burst;
                                if (s_req_type == REQ_READ) begin
                                    rd_idx_next = rd_idx_reg + IDX_W'(n_burst);
                                end
                            end
                        end
                        REQ_ADV_READ: begin
                            load_single = 1'b1;
                            rd_idx_next = rd_idx_reg + IDX_W'(s_count);
                        end
                        REQ_ADV_WRITE: begin
                            load_single = 1'b1;
                            wr_idx_next = wr_idx_reg + IDX_W'(s_count);
                        end
                        REQ_CLEAR: begin
                            load_single   = 1'b1;
                            rd_idx_next   = '0;
                            wr_idx_next   = '0;
                            clr_addr_next = '0;
                            state_next    = ST_CLEAR;
                        end
                        default: begin
                            load_single = 1'b1;
                        end
                    endcase
                end
            end
            ST_BURST: begin
                if (issue) begin
                    rd_addr_next    = rd_addr_reg + IDX_W'(1);
                    issue_left_next = issue_left_reg - BURST_W'(1);
                end
                if (deliver) begin
                    deliver_left_next = deliver_left_reg - BURST_W'(1);
                    if (deliver_left_reg == BURST_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_CLEAR;
            rd_idx_reg       <= '0;
            wr_idx_reg       <= '0;
            clr_addr_reg     <= '0;
            issue_left_reg   <= '0;
            deliver_left_reg <= '0;
            rd_pend_reg      <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            rd_idx_reg       <= rd_idx_next;
            wr_idx_reg       <= wr_idx_next;
            clr_addr_reg     <= clr_addr_next;
            issue_left_reg   <= issue_left_next;
            deliver_left_reg <= deliver_left_next;
            rd_pend_reg      <= rd_pend_next;
            if (load_single || deliver) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_addr_reg <= rd_addr_next;
        if (load_single) begin
            data_out_reg   <= '0;
            elem_valid_reg <= 1'b0;
            last_reg       <= 1'b1;
            accepted_reg   <= single_acc;
            fill_reg       <= LVL_W'(fill_nx);
            free_reg       <= LVL_W'(free_nx);
        end else if (deliver) begin
            data_out_reg   <= DATA_W'(mem_rdata);
            elem_valid_reg <= 1'b1;
            last_reg       <= (deliver_left_reg == BURST_W'(1));
            accepted_reg   <= 1'b0;
            fill_reg       <= LVL_W'(fill_nx);
            free_reg       <= LVL_W'(free_nx);
        end
    end

    rbf_mem #(
        .DEPTH (DEPTH),
        .WIDTH (ELEM_WIDTH)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (issue),
        .raddr (rd_addr_reg),
        .rdata (mem_rdata)
    );

    assign m_valid         = m_valid_reg;
    assign m_data_out      = data_out_reg;
    assign m_element_valid = elem_valid_reg;
    assign m_last          = last_reg;
    assign m_accepted      = accepted_reg;
    assign m_fill_level    = fill_reg;
    assign m_free_level    = free_reg;

endmodule

FILE: sim/rbf_checker.sv
// Result checker for the ring buffer FIFO: follows request and result transfers,
// keeps a shadow copy of the buffer and indices, and compares every result.
// Depends on rbf_pkg.
module rbf_checker #(
    parameter int DEPTH     = rbf_pkg::DEPTH_DEF,
    parameter int MAX_BURST = rbf_pkg::MAX_BURST_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [rbf_pkg::REQ_W-1:0]  s_req_type,
    input  logic [rbf_pkg::DATA_W-1:0] s_data_in,
    input  logic [rbf_pkg::CNT_W-1:0]  s_count,

    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic [rbf_pkg::DATA_W-1:0] m_data_out,
    input  logic                       m_element_valid,
    input  logic                       m_last,
    input  logic                       m_accepted,
    input  logic [rbf_pkg::LVL_W-1:0]  m_fill_level,
    input  logic [rbf_pkg::LVL_W-1:0]  m_free_level,

    output int                         mismatches,
    output int                         pending
);

    import rbf_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              elem_valid;
        logic              last;
        logic              accepted;
        logic [LVL_W-1:0]  fill;
        logic [LVL_W-1:0]  space;
    } fifo_result_t;

    fifo_result_t      expected_q[$];
    logic [DATA_W-1:0] shadow_mem [DEPTH];
    logic [IDX_W-1:0]  rd_ptr;
    logic [IDX_W-1:0]  wr_ptr;

    task automatic wipe_shadow();
        for (int i = 0; i < DEPTH; i++) shadow_mem[i] = '0;
        rd_ptr = '0;
        wr_ptr = '0;
    endtask

    // Levels are taken after the indices have moved for this request.
    task automatic push_result(input logic [DATA_W-1:0] data, input logic ev,
                               input logic lst, input logic acc);
        fifo_result_t     r;
        logic [IDX_W-1:0] used;
        logic [IDX_W-1:0] room;
        used         = wr_ptr - rd_ptr;
        room         = rd_ptr - wr_ptr - 1'b1;
        r.data       = data;
        r.elem_valid = ev;
        r.last       = lst;
        r.accepted   = acc;
        r.fill       = LVL_W'(used);
        r.space      = LVL_W'(room);
        expected_q.push_back(r);
    endtask

    task automatic predict_request(input logic [REQ_W-1:0] rq,
                                   input logic [DATA_W-1:0] din,
                                   input logic [CNT_W-1:0] cnt);
        logic [IDX_W-1:0] avail;
        logic [IDX_W-1:0] room;
        logic [IDX_W-1:0] start;
        logic [IDX_W-1:0] slot;
        int               n;
        avail = wr_ptr - rd_ptr;
        room  = rd_ptr - wr_ptr - 1'b1;
        case (rq)
            REQ_WRITE: begin
                if (room != 0) begin
                    shadow_mem[wr_ptr] = din;
                    wr_ptr = wr_ptr + 1'b1;
                    push_result('0, 1'b0, 1'b1, 1'b1);
                end else begin
                    push_result('0, 1'b0, 1'b1, 1'b0);
                end
                return;
            end
            REQ_READ, REQ_PEEK: begin
                n = int'(cnt);
                if (int'(avail) < n) n = int'(avail);
                if (n > MAX_BURST) n = MAX_BURST;
                if (n != 0) begin
                    start = rd_ptr;
                    if (rq == REQ_READ) rd_ptr = rd_ptr + IDX_W'(n);
                    for (int i = 0; i < n; i++) begin
                        slot = start + IDX_W'(i);
                        push_result(shadow_mem[slot], 1'b1, i == n - 1, 1'b0);
                    end
                    return;
                end
            end
            REQ_ADV_READ:  rd_ptr = rd_ptr + IDX_W'(cnt);
            REQ_ADV_WRITE: wr_ptr = wr_ptr + IDX_W'(cnt);
            REQ_CLEAR:     wipe_shadow();
            default: ;
        endcase
        push_result('0, 1'b0, 1'b1, 1'b0);
    endtask

    task automatic check_field(input string what, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        fifo_result_t want;
        if (!aresetn) begin
            wipe_shadow();
            expected_q.delete();
            mismatches = 0;
        end else begin
            if (s_valid && s_ready) predict_request(s_req_type, s_data_in, s_count);
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual data %0h last %0b",
                             $time, m_data_out, m_last);
                    mismatches++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("data_out", want.data, m_data_out);
                    check_field("element_valid", DATA_W'(want.elem_valid),
                                DATA_W'(m_element_valid));
                    check_field("last", DATA_W'(want.last), DATA_W'(m_last));
                    check_field("accepted", DATA_W'(want.accepted), DATA_W'(m_accepted));
                    check_field("fill_level", DATA_W'(want.fill), DATA_W'(m_fill_level));
                    check_field("free_level", DATA_W'(want.space), DATA_W'(m_free_level));
                end
            end
        end
        pending = expected_q.size();
    end

endmodule

FILE: sim/tb_top.sv
// Testbench top for the ring buffer FIFO: clock, reset, request stimulus and
// result-side flow control; the verdict comes from rbf_checker's counts.
// Depends on rbf_pkg, ring_buffer_fifo and rbf_checker.
module tb_top;
    import rbf_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 290;
    localparam int CALM_ITEMS   = 40;
    localparam int HOLD_START   = 3000;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 100;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [REQ_W-1:0]  s_req_type;
    logic [DATA_W-1:0] s_data_in;
    logic [CNT_W-1:0]  s_count;
    logic              m_valid;
    logic              m_ready;
    logic [DATA_W-1:0] m_data_out;
    logic              m_element_valid;
    logic              m_last;
    logic              m_accepted;
    logic [LVL_W-1:0]  m_fill_level;
    logic [LVL_W-1:0]  m_free_level;

    int   mismatches;
    int   pending;
    logic calm_tail;

    ring_buffer_fifo uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_data_in       (s_data_in),
        .s_count         (s_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data_out      (m_data_out),
        .m_element_valid (m_element_valid),
        .m_last          (m_last),
        .m_accepted      (m_accepted),
        .m_fill_level    (m_fill_level),
        .m_free_level    (m_free_level)
    );

    rbf_checker result_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_data_in       (s_data_in),
        .s_count         (s_count),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data_out      (m_data_out),
        .m_element_valid (m_element_valid),
        .m_last          (m_last),
        .m_accepted      (m_accepted),
        .m_fill_level    (m_fill_level),
        .m_free_level    (m_free_level),
        .mismatches      (mismatches),
        .pending         (pending)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("Some tests failed");
        $finish;
    end

    // Result side: short random stalls, one long hold-off so the block backs
    // up into its request port, and no stalls during the calm tail.
    initial begin : result_sink
        int stall;
        int sink_cycles;
        m_ready = 1'b0;
        sink_cycles = 0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            sink_cycles++;
            if (sink_cycles == HOLD_START) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            if (!calm_tail && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                stall = $urandom_range(1, 3);
                repeat (stall - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Call at a falling edge; returns at the falling edge after the transfer.
    task automatic send_req(input logic [REQ_W-1:0] rq, input logic [DATA_W-1:0] din,
                            input logic [CNT_W-1:0] cnt);
        if (!calm_tail && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= rq;
        s_data_in  <= din;
        s_count    <= cnt;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [DATA_W-1:0] pick_data();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] pick_burst();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return CNT_W'($urandom_range(0, 1023));
            2:       return '1;
            default: return CNT_W'($urandom_range(1, 8));
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] pick_stride();
        if ($urandom_range(0, 3) == 0) return CNT_W'($urandom_range(0, 1023));
        return CNT_W'($urandom_range(0, 6));
    endfunction

    initial begin : stimulus
        int roll;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_req_type = REQ_QUERY;
        s_data_in  = '0;
        s_count    = '0;
        calm_tail  = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Empty buffer: space query, empty read, empty peek.
        send_req(REQ_QUERY, '0, '0);
        send_req(REQ_READ, '0, 10'd5);
        send_req(REQ_PEEK, '1, '1);
        send_req(REQ_WRITE, 32'h0000_0000, '0);
        send_req(REQ_WRITE, 32'hFFFF_FFFF, '1);
        send_req(REQ_WRITE, 32'hA5A5_5A5A, 10'd3);
        // Zero count reads nothing even with data buffered.
        send_req(REQ_PEEK, '0, '0);
        send_req(REQ_READ, '0, '0);
        send_req(REQ_PEEK, '0, '1);
        send_req(REQ_READ, '0, 10'd1);
        send_req(REQ_READ, '0, '1);
        // Jump the write index so the buffer reads as full, then try a write.
        send_req(REQ_ADV_WRITE, '0, '1);
        send_req(REQ_WRITE, 32'h1234_5678, '0);
        // Burst capped at the maximum length.
        send_req(REQ_READ, '0, '1);
        // Advance the read index by 1023, which wraps it to one place before where it was.
        send_req(REQ_ADV_READ, '0, '1);
        send_req(REQ_UNUSED, '1, '1);
        send_req(REQ_QUERY, '0, '0);
        send_req(REQ_CLEAR, '0, '0);
        send_req(REQ_QUERY, '0, '0);
        send_req(REQ_WRITE, 32'hDEAD_BEEF, '0);
        send_req(REQ_ADV_WRITE, '0, 10'd64);
        send_req(REQ_PEEK, '0, 10'd100);
        send_req(REQ_READ, '0, 10'd65);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS - CALM_ITEMS) calm_tail = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 45)      send_req(REQ_WRITE, pick_data(),
                                         CNT_W'($urandom_range(0, 1023)));
            else if (roll < 65) send_req(REQ_READ, $urandom, pick_burst());
            else if (roll < 77) send_req(REQ_PEEK, $urandom, pick_burst());
            else if (roll < 83) send_req(REQ_ADV_READ, $urandom, pick_stride());
            else if (roll < 89) send_req(REQ_ADV_WRITE, $urandom, pick_stride());
            else if (roll < 94) send_req(REQ_QUERY, $urandom,
                                         CNT_W'($urandom_range(0, 1023)));
            else if (roll < 98) send_req(REQ_UNUSED, $urandom,
                                         CNT_W'($urandom_range(0, 1023)));
            else                send_req(REQ_CLEAR, $urandom,
                                         CNT_W'($urandom_range(0, 1023)));
        end
        s_valid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
